[rtl/rgtr_pkg.sv]
// ============================================================================
// rgtr_pkg
// Shared types, register codes and constants for the gray/rotate core.
// ============================================================================
package rgtr_pkg;

   localparam int unsigned DEFAULT_MAX_DIM = 4096;
   localparam int unsigned QUEUE_DEPTH     = 2;

   localparam int unsigned PIXEL_W   = 32;
   localparam int unsigned RGB_W     = 24;
   localparam int unsigned GRAY_W    = 8;
   localparam int unsigned ADDR_W    = 24;
   localparam int unsigned CSR_W     = 13;
   localparam int unsigned CSR_IDX_W = 2;

   // luminance weights, scaled by 1024
   localparam int unsigned WEIGHT_B  = 117;
   localparam int unsigned WEIGHT_G  = 601;
   localparam int unsigned WEIGHT_R  = 306;
   localparam int unsigned LUMA_W    = 18;
   localparam int unsigned LUMA_SHIFT = 10;

   typedef enum logic [1:0] {
      ROT_NONE          = 2'd0,
      ROT_QUARTER       = 2'd1,
      ROT_HALF          = 2'd2,
      ROT_THREE_QUARTER = 2'd3
   } rot_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_ROTATION     = 2'd2
   } csr_index_type;

   // zero acts as one, oversize saturates
   function automatic logic [31:0] clamp_dim(logic [CSR_W-1:0] v, int unsigned max_dim);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0) begin
         return 32'd1;
      end
      if (v32 > 32'(max_dim)) begin
         return 32'(max_dim);
      end
      return v32;
   endfunction

endpackage

[rtl/rgtr_front.sv]
// ============================================================================
// rgtr_front
// Accepts pixels, owns the config registers and the column/row counters, and
// turns each pixel into a queue entry of multiplier operands.
// ============================================================================
module rgtr_front #(
   parameter int unsigned MAX_DIM = rgtr_pkg::DEFAULT_MAX_DIM,
   parameter int unsigned CNT_W   = $clog2(MAX_DIM),
   parameter int unsigned DIM_W   = $clog2(MAX_DIM + 1),
   parameter int unsigned ENTRY_W = rgtr_pkg::RGB_W + 2 * CNT_W + DIM_W + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rgtr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rgtr_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rgtr_pkg::PIXEL_W-1:0]    req_pixel_word,
   output logic                            q_valid,
   input  logic                            q_ready,
   output logic [ENTRY_W-1:0]              q_data
);

   logic [DIM_W-1:0]      width_ff,  width_in;
   logic [DIM_W-1:0]      height_ff, height_in;
   rgtr_pkg::rot_type     rotation_ff, rotation_in;
   logic [CNT_W-1:0]      col_ff, col_in;
   logic [CNT_W-1:0]      row_ff, row_in;

   logic [DIM_W-1:0]      width_m1, height_m1;
   logic [CNT_W-1:0]      col_rev, row_rev;
   logic                  col_end, row_end;
   logic [CNT_W-1:0]      op_a, op_c;
   logic [DIM_W-1:0]      op_b;
   logic                  accept;

   assign req_ready = q_ready;
   assign q_valid   = req_valid;
   assign accept    = req_valid && q_ready;

   assign width_m1  = width_ff - DIM_W'(1);
   assign height_m1 = height_ff - DIM_W'(1);
   assign col_rev   = CNT_W'(width_m1 - DIM_W'(col_ff));
   assign row_rev   = CNT_W'(height_m1 - DIM_W'(row_ff));
   assign col_end   = (DIM_W'(col_ff) == width_m1);
   assign row_end   = (DIM_W'(row_ff) == height_m1);

   // address = op_a * op_b + op_c
   always_comb begin
      case (rotation_ff)
         rgtr_pkg::ROT_QUARTER: begin
            op_a = col_ff;  op_b = height_ff; op_c = row_rev;
         end
         rgtr_pkg::ROT_HALF: begin
            op_a = row_rev; op_b = width_ff;  op_c = col_rev;
         end
         rgtr_pkg::ROT_THREE_QUARTER: begin
            op_a = col_rev; op_b = height_ff; op_c = row_ff;
         end
         default: begin
            op_a = row_ff;  op_b = width_ff;  op_c = col_ff;
         end
      endcase
   end

   assign q_data = {req_pixel_word[31:8], op_a, op_b, op_c, col_end && row_end};

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      rotation_in = rotation_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (csr_we) begin
         case (rgtr_pkg::csr_index_type'(csr_index))
            rgtr_pkg::CSR_IMAGE_WIDTH: begin
               width_in = DIM_W'(rgtr_pkg::clamp_dim(csr_wdata, MAX_DIM));
               col_in   = '0;
               row_in   = '0;
            end
            rgtr_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = DIM_W'(rgtr_pkg::clamp_dim(csr_wdata, MAX_DIM));
               col_in    = '0;
               row_in    = '0;
            end
            rgtr_pkg::CSR_ROTATION: begin
               rotation_in = rgtr_pkg::rot_type'(csr_wdata[1:0]);
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DIM_W'(1);
         height_ff   <= DIM_W'(1);
         rotation_ff <= rgtr_pkg::ROT_NONE;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         rotation_ff <= rotation_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

endmodule

[rtl/rgtr_queue.sv]
// ============================================================================
// rgtr_queue
// Small register FIFO between the front and back parts.
// ============================================================================
module rgtr_queue #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = rgtr_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  logic [DATA_W-1:0] wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output logic [DATA_W-1:0] rd_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              push, pop;

   assign wr_ready = (count_ff != CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/rgtr_back.sv]
// ============================================================================
// rgtr_back
// Two-stage elastic pipeline: products, then sums into the output register.
// ============================================================================
module rgtr_back #(
   parameter int unsigned MAX_DIM = rgtr_pkg::DEFAULT_MAX_DIM,
   parameter int unsigned CNT_W   = $clog2(MAX_DIM),
   parameter int unsigned DIM_W   = $clog2(MAX_DIM + 1),
   parameter int unsigned ENTRY_W = rgtr_pkg::RGB_W + 2 * CNT_W + DIM_W + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ENTRY_W-1:0]            in_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rgtr_pkg::GRAY_W-1:0]   rsp_gray_value,
   output logic [rgtr_pkg::ADDR_W-1:0]   rsp_dest_address,
   output logic                          rsp_frame_last
);

   localparam int unsigned LW     = rgtr_pkg::LUMA_W;
   localparam int unsigned PROD_W = CNT_W + DIM_W;
   localparam int unsigned SUM_W  = (PROD_W > rgtr_pkg::ADDR_W) ? PROD_W : rgtr_pkg::ADDR_W;

   logic [7:0]        red, green, blue;
   logic [CNT_W-1:0]  op_a, op_c;
   logic [DIM_W-1:0]  op_b;
   logic              last;

   logic              s1_valid_ff, s1_valid_in;
   logic [LW-1:0]     prod_b_ff, prod_g_ff, prod_r_ff;
   logic [PROD_W-1:0] prod_addr_ff;
   logic [CNT_W-1:0]  add_ff;
   logic              last_s1_ff;
   logic              s1_ready, s1_load;

   logic              s2_valid_ff, s2_valid_in;
   logic [rgtr_pkg::GRAY_W-1:0] gray_ff;
   logic [rgtr_pkg::ADDR_W-1:0] addr_ff;
   logic              last_s2_ff;
   logic              s2_ready, s2_load;
   logic [LW-1:0]     luma;
   logic [SUM_W-1:0]  addr_sum;

   assign {red, green, blue, op_a, op_b, op_c, last} = in_data;

   assign s2_ready = !s2_valid_ff || rsp_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;
   assign s1_load  = in_valid && s1_ready;
   assign s2_load  = s1_valid_ff && s2_ready;

   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   assign luma     = prod_b_ff + prod_g_ff + prod_r_ff;
   assign addr_sum = SUM_W'(prod_addr_ff) + SUM_W'(add_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         prod_b_ff    <= LW'(blue)  * LW'(rgtr_pkg::WEIGHT_B);
         prod_g_ff    <= LW'(green) * LW'(rgtr_pkg::WEIGHT_G);
         prod_r_ff    <= LW'(red)   * LW'(rgtr_pkg::WEIGHT_R);
         prod_addr_ff <= PROD_W'(op_a) * PROD_W'(op_b);
         add_ff       <= op_c;
         last_s1_ff   <= last;
      end
      if (s2_load) begin
         gray_ff    <= luma[rgtr_pkg::LUMA_SHIFT +: rgtr_pkg::GRAY_W];
         addr_ff    <= addr_sum[rgtr_pkg::ADDR_W-1:0];
         last_s2_ff <= last_s1_ff;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_gray_value   = gray_ff;
   assign rsp_dest_address = addr_ff;
   assign rsp_frame_last   = last_s2_ff;

endmodule

[rtl/rgba_to_gray_rotate_core.sv]
// ============================================================================
// rgba_to_gray_rotate_core
// RGB pixel to 8-bit gray, with the pixel's address in a rotated frame.
// ============================================================================
// Takes one pixel per cycle in source raster order and returns one result per
// pixel, in order, one per cycle sustained while rsp_ready stays high. An
// accepted pixel is written into a two-entry queue; the back pipeline then
// forms the luminance products and the row/column product in one stage and
// adds them into the output register, which drives rsp_valid, in the next.
// Writing the width or height restarts the frame at column 0, row 0; a
// rotation write applies from the next pixel. Sizes of 0 act as 1 and sizes
// above MAX_DIM saturate. Write the registers only while no pixel is in flight.
module rgba_to_gray_rotate_core #(
   parameter int unsigned MAX_DIM = rgtr_pkg::DEFAULT_MAX_DIM
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [rgtr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rgtr_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rgtr_pkg::PIXEL_W-1:0]   req_pixel_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [rgtr_pkg::GRAY_W-1:0]    rsp_gray_value,
   output logic [rgtr_pkg::ADDR_W-1:0]    rsp_dest_address,
   output logic                           rsp_frame_last
);

   localparam int unsigned CNT_W   = $clog2(MAX_DIM);
   localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
   localparam int unsigned ENTRY_W = rgtr_pkg::RGB_W + 2 * CNT_W + DIM_W + 1;

   logic               fq_valid, fq_ready;
   logic [ENTRY_W-1:0] fq_data;
   logic               qb_valid, qb_ready;
   logic [ENTRY_W-1:0] qb_data;

   rgtr_front #(
      .MAX_DIM (MAX_DIM),
      .CNT_W   (CNT_W),
      .DIM_W   (DIM_W),
      .ENTRY_W (ENTRY_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_word (req_pixel_word),
      .q_valid        (fq_valid),
      .q_ready        (fq_ready),
      .q_data         (fq_data)
   );

   rgtr_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (rgtr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  (fq_data),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_data  (qb_data)
   );

   rgtr_back #(
      .MAX_DIM (MAX_DIM),
      .CNT_W   (CNT_W),
      .DIM_W   (DIM_W),
      .ENTRY_W (ENTRY_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (qb_valid),
      .in_ready         (qb_ready),
      .in_data          (qb_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_gray_value   (rsp_gray_value),
      .rsp_dest_address (rsp_dest_address),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule

[tb/sv/tb_rgba_to_gray_rotate_core.sv]
// ============================================================================
// tb_rgba_to_gray_rotate_core
// Self-checking bench for the gray conversion and frame rotation core.
// ============================================================================
// Pixels go in through a bursty valid/ready driver. A predictor tracks the
// column and row position and the register settings, and stores the gray
// value, rotated address and end-of-frame flag of every accepted pixel. The
// monitor checks each result against the oldest stored one while the
// receiver stalls on its own pattern. Registers change only between phases,
// once the core has drained.
module tb_rgba_to_gray_rotate_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RESET_CYCLES  = 12;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned TOTAL_PIXELS  = 1150;
   localparam int unsigned DIM_LIMIT     = rgtr_pkg::DEFAULT_MAX_DIM;
   localparam logic [rgtr_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // receiver stall modes
   localparam int unsigned READY_ALWAYS = 0;
   localparam int unsigned READY_RANDOM = 1;
   localparam int unsigned READY_SPARSE = 2;
   localparam int unsigned READY_HALT   = 3;

   typedef struct packed {
      logic [rgtr_pkg::GRAY_W-1:0] gray;
      logic [rgtr_pkg::ADDR_W-1:0] addr;
      logic                        last;
   } pixel_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [rgtr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rgtr_pkg::CSR_W-1:0]     csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [rgtr_pkg::PIXEL_W-1:0]   req_pixel_word = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [rgtr_pkg::GRAY_W-1:0]    rsp_gray_value;
   logic [rgtr_pkg::ADDR_W-1:0]    rsp_dest_address;
   logic                           rsp_frame_last;

   rgba_to_gray_rotate_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_word   (req_pixel_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_gray_value   (rsp_gray_value),
      .rsp_dest_address (rsp_dest_address),
      .rsp_frame_last   (rsp_frame_last)
   );

   always #5 clock = ~clock;

   // predictor copy of the registers and the raster position
   logic [rgtr_pkg::CSR_W-1:0] cfg_width  = 13'd1;
   logic [rgtr_pkg::CSR_W-1:0] cfg_height = 13'd1;
   rgtr_pkg::rot_type          cfg_rot    = rgtr_pkg::ROT_NONE;
   int unsigned                col_pos    = 0;
   int unsigned                row_pos    = 0;

   logic [rgtr_pkg::PIXEL_W-1:0] pixel_backlog[$];
   pixel_result_type             expected_results[$];

   int unsigned pixels_queued   = 0;
   int unsigned pixels_accepted = 0;
   int unsigned results_checked = 0;
   int unsigned frames_closed   = 0;
   int unsigned phase_count     = 0;
   int unsigned error_count     = 0;
   logic [3:0]  rot_seen        = '0;

   function automatic int unsigned effective_dim(logic [rgtr_pkg::CSR_W-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > DIM_LIMIT) begin
         return DIM_LIMIT;
      end
      return int'(v);
   endfunction

   // gray value and rotated address of one pixel; advances the position
   function automatic pixel_result_type predict_pixel(logic [rgtr_pkg::PIXEL_W-1:0] word);
      pixel_result_type res;
      int unsigned      w;
      int unsigned      h;
      int unsigned      luma;
      int unsigned      addr;
      w = effective_dim(cfg_width);
      h = effective_dim(cfg_height);
      luma = int'(word[15:8]) * rgtr_pkg::WEIGHT_B + int'(word[23:16]) * rgtr_pkg::WEIGHT_G
           + int'(word[31:24]) * rgtr_pkg::WEIGHT_R;
      case (cfg_rot)
         rgtr_pkg::ROT_QUARTER:       addr = col_pos * h + (h - 1 - row_pos);
         rgtr_pkg::ROT_HALF:          addr = (h - 1 - row_pos) * w + (w - 1 - col_pos);
         rgtr_pkg::ROT_THREE_QUARTER: addr = (w - 1 - col_pos) * h + row_pos;
         default:                     addr = row_pos * w + col_pos;
      endcase
      res.gray = rgtr_pkg::GRAY_W'(luma >> rgtr_pkg::LUMA_SHIFT);
      res.addr = rgtr_pkg::ADDR_W'(addr);
      res.last = (col_pos == w - 1) && (row_pos == h - 1);
      rot_seen[cfg_rot] = 1'b1;
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- driver
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      logic                         next_valid;
      logic [rgtr_pkg::PIXEL_W-1:0] next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_pixel(req_pixel_word));
            pixels_accepted++;
         end
         if (!req_valid || req_ready) begin
            next_valid = 1'b0;
            next_word  = req_pixel_word;
            if (gap_left != 0) begin
               gap_left--;
            end else if (pixel_backlog.size() != 0) begin
               next_valid = 1'b1;
               next_word  = pixel_backlog.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            req_valid      <= next_valid;
            req_pixel_word <= next_word;
         end
      end
   end

   // -------------------------------------------------------------- receiver
   int unsigned ready_mode = READY_ALWAYS;
   int unsigned mode_left  = 0;

   always @(posedge clock) begin
      logic next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(READY_ALWAYS, READY_HALT);
            mode_left  = (ready_mode == READY_HALT) ? $urandom_range(1, 12)
                                                    : $urandom_range(4, 60);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            READY_RANDOM: next_ready = $urandom_range(0, 1);
            READY_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
            READY_HALT:   next_ready = 1'b0;
            default:      next_ready = 1'b1;
         endcase
         rsp_ready <= next_ready;
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin
      pixel_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: result with nothing pending: gray %0d addr %0d last %0b",
                     $time, rsp_gray_value, rsp_dest_address, rsp_frame_last);
         end else begin
            exp_res = expected_results.pop_front();
            results_checked++;
            if (rsp_frame_last) begin
               frames_closed++;
            end
            if (rsp_gray_value !== exp_res.gray) begin
               error_count++;
               $display("%0t: gray_value expected %0d actual %0d",
                        $time, exp_res.gray, rsp_gray_value);
            end
            if (rsp_dest_address !== exp_res.addr) begin
               error_count++;
               $display("%0t: dest_address expected %0d actual %0d",
                        $time, exp_res.addr, rsp_dest_address);
            end
            if (rsp_frame_last !== exp_res.last) begin
               error_count++;
               $display("%0t: frame_last expected %0b actual %0b",
                        $time, exp_res.last, rsp_frame_last);
            end
         end
      end
   end

   // ------------------------------------------------------------- stimulus
   task automatic write_csr(logic [rgtr_pkg::CSR_IDX_W-1:0] idx,
                            logic [rgtr_pkg::CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         rgtr_pkg::CSR_IMAGE_WIDTH: begin
            cfg_width = data;
            col_pos   = 0;
            row_pos   = 0;
         end
         rgtr_pkg::CSR_IMAGE_HEIGHT: begin
            cfg_height = data;
            col_pos    = 0;
            row_pos    = 0;
         end
         rgtr_pkg::CSR_ROTATION: begin
            cfg_rot = rgtr_pkg::rot_type'(data[1:0]);
         end
         default: begin
         end
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_pixel(logic [rgtr_pkg::PIXEL_W-1:0] word);
      pixel_backlog.push_back(word);
      pixels_queued++;
   endtask

   task automatic drain_all();
      while (pixel_backlog.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [rgtr_pkg::CSR_W-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0:       return '0;
         1: begin
            case ($urandom_range(0, 2))
               0:       return rgtr_pkg::CSR_W'(DIM_LIMIT);
               1:       return rgtr_pkg::CSR_W'(DIM_LIMIT + 1);
               default: return '1;
            endcase
         end
         2:       return rgtr_pkg::CSR_W'($urandom_range(0, 8191));
         default: return rgtr_pkg::CSR_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [rgtr_pkg::PIXEL_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int unsigned frame_size;
      int unsigned burst_count;
      int unsigned choice;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes: every pixel is a one-pixel frame
      queue_pixel(32'h0000_0000);
      queue_pixel(32'hFFFF_FFFF);
      queue_pixel(32'h0000_00FF);
      drain_all();

      // 3x2 frame, rotation changed mid-frame keeps the position
      write_csr(rgtr_pkg::CSR_IMAGE_WIDTH, 13'd3);
      write_csr(rgtr_pkg::CSR_IMAGE_HEIGHT, 13'd2);
      write_csr(rgtr_pkg::CSR_ROTATION, rgtr_pkg::CSR_W'(rgtr_pkg::ROT_NONE));
      queue_pixel(32'hFF00_0000);
      queue_pixel(32'h00FF_0000);
      drain_all();
      write_csr(rgtr_pkg::CSR_ROTATION, rgtr_pkg::CSR_W'(rgtr_pkg::ROT_HALF));
      queue_pixel(32'h0000_FF00);
      queue_pixel(32'h1234_5678);
      queue_pixel(pick_pixel());
      queue_pixel(pick_pixel());
      drain_all();
      write_csr(rgtr_pkg::CSR_ROTATION, rgtr_pkg::CSR_W'(rgtr_pkg::ROT_QUARTER));
      repeat (3) queue_pixel(pick_pixel());
      drain_all();
      write_csr(rgtr_pkg::CSR_ROTATION, rgtr_pkg::CSR_W'(rgtr_pkg::ROT_THREE_QUARTER));
      repeat (3) queue_pixel(pick_pixel());
      drain_all();

      // size write in the middle of a frame restarts it
      queue_pixel(pick_pixel());
      drain_all();
      write_csr(rgtr_pkg::CSR_IMAGE_WIDTH, 13'd2);
      repeat (4) queue_pixel(pick_pixel());
      drain_all();

      // zero sizes act as one
      write_csr(rgtr_pkg::CSR_IMAGE_WIDTH, 13'd0);
      write_csr(rgtr_pkg::CSR_IMAGE_HEIGHT, 13'd0);
      repeat (2) queue_pixel(pick_pixel());
      drain_all();

      // oversize saturates; 180 degrees puts the first pixel at the top address
      write_csr(rgtr_pkg::CSR_IMAGE_WIDTH, 13'h1FFF);
      write_csr(rgtr_pkg::CSR_IMAGE_HEIGHT, rgtr_pkg::CSR_W'(DIM_LIMIT + 1));
      write_csr(rgtr_pkg::CSR_ROTATION, rgtr_pkg::CSR_W'(rgtr_pkg::ROT_HALF));
      repeat (2) queue_pixel(pick_pixel());
      drain_all();
      write_csr(rgtr_pkg::CSR_ROTATION, rgtr_pkg::CSR_W'(rgtr_pkg::ROT_QUARTER));
      queue_pixel(pick_pixel());
      drain_all();
      write_csr(rgtr_pkg::CSR_ROTATION, rgtr_pkg::CSR_W'(rgtr_pkg::ROT_THREE_QUARTER));
      queue_pixel(pick_pixel());
      drain_all();

      // write to the unmapped index is dropped
      write_csr(CSR_UNMAPPED, 13'h1FFF);
      write_csr(rgtr_pkg::CSR_ROTATION, rgtr_pkg::CSR_W'(rgtr_pkg::ROT_NONE));
      repeat (2) queue_pixel(pick_pixel());
      drain_all();

      // random phases, mostly small frames run to completion
      while (pixels_queued < TOTAL_PIXELS) begin
         choice = $urandom_range(0, 9);
         if (choice <= 5) begin
            write_csr(rgtr_pkg::CSR_IMAGE_WIDTH, pick_dim());
            write_csr(rgtr_pkg::CSR_IMAGE_HEIGHT, pick_dim());
            write_csr(rgtr_pkg::CSR_ROTATION, rgtr_pkg::CSR_W'($urandom_range(0, 3)));
         end else if (choice <= 7) begin
            write_csr(rgtr_pkg::CSR_ROTATION, rgtr_pkg::CSR_W'($urandom_range(0, 8191)));
         end else if (choice == 8) begin
            write_csr(CSR_UNMAPPED, rgtr_pkg::CSR_W'($urandom_range(0, 8191)));
         end
         frame_size = effective_dim(cfg_width) * effective_dim(cfg_height);
         if (frame_size <= 64) begin
            burst_count = frame_size * $urandom_range(1, 3)
                        + $urandom_range(0, frame_size - 1);
         end else begin
            burst_count = $urandom_range(1, 48);
         end
         if (burst_count > TOTAL_PIXELS - pixels_queued) begin
            burst_count = TOTAL_PIXELS - pixels_queued;
         end
         repeat (burst_count) queue_pixel(pick_pixel());
         drain_all();
         phase_count++;
      end

      drain_all();
      $display("Checked %0d of %0d pixels over %0d random phases, %0d frame ends seen,",
               results_checked, pixels_accepted, phase_count, frames_closed);
      $display("rotation settings exercised (bit per setting): %b", rot_seen);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding", expected_results.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[rgba_to_gray_rotate_core.f]
rtl/rgtr_pkg.sv
rtl/rgtr_front.sv
rtl/rgtr_queue.sv
rtl/rgtr_back.sv
rtl/rgba_to_gray_rotate_core.sv
tb/sv/tb_rgba_to_gray_rotate_core.sv
